// ===== hw/rtl/delta_stepping_relax_engine_core_assert.svh =====
// assertion macros used by the relax engine checker
`ifndef DELTA_STEPPING_RELAX_ENGINE_CORE_ASSERT_SVH
`define DELTA_STEPPING_RELAX_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define DSRE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsre: same-cycle check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define DSRE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsre: next-cycle check failed");

`endif

// ===== hw/rtl/dsre_pkg.sv =====
// shared constants and types of the delta-stepping relax engine
package dsre_pkg;

   localparam int VERTICES = 1024;
   localparam int VTX_W    = $clog2(VERTICES);
   localparam int PAR_W    = $clog2(VERTICES + 1);
   localparam int DIST_W   = 31;
   localparam int BKT_W    = 31;
   localparam int DELTA_W  = 16;
   localparam int WGT_W    = 16;
   localparam int PEND_W   = 11;
   localparam int OP_W     = 2;

   localparam logic [DIST_W-1:0] INF_DIST  = '1;
   localparam logic [BKT_W-1:0]  EMPTY_BKT = '1;
   localparam logic [PAR_W-1:0]  NO_PARENT = PAR_W'(VERTICES);
   localparam logic [PEND_W-1:0] PEND_MAX  = '1;

   typedef enum logic [OP_W-1:0] {
      OP_RELAX = 2'd0,
      OP_POP   = 2'd1,
      OP_SEED  = 2'd2
   } op_type;

   typedef struct packed {
      logic [DIST_W-1:0] path_len;
      logic [PAR_W-1:0]  parent;
      logic [BKT_W-1:0]  bucket;
   } entry_type;

   localparam entry_type ENTRY_RESET =
      '{path_len: INF_DIST, parent: NO_PARENT, bucket: EMPTY_BKT};

endpackage

// ===== hw/rtl/dsre_div.sv =====
// radix-2 restoring divider for the bucket index, one quotient bit per cycle
module dsre_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dsre_pkg::DIST_W-1:0]    dividend,
   input  logic [dsre_pkg::DELTA_W-1:0]   divisor,
   output logic                           done,
   output logic [dsre_pkg::BKT_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(dsre_pkg::DIST_W);

   logic                            run_ff,  run_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff,  cnt_in;
   logic [dsre_pkg::DELTA_W-1:0]    rem_ff,  rem_in;
   logic [dsre_pkg::DIST_W-1:0]     quo_ff,  quo_in;
   logic [dsre_pkg::DELTA_W-1:0]    dvs_ff,  dvs_in;
   logic [dsre_pkg::DELTA_W:0]      trial;
   logic                            ge;

   // one trial subtraction per cycle
   assign trial = {rem_ff, quo_ff[dsre_pkg::DIST_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? dsre_pkg::DELTA_W'(trial - {1'b0, dvs_ff})
                     : dsre_pkg::DELTA_W'(trial);
         quo_in = {quo_ff[dsre_pkg::DIST_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(dsre_pkg::DIST_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/delta_stepping_relax_engine_core.sv =====
// top level of the delta-stepping relax engine: vertex store, sequencer, result register
//
// Use: an item (relax edge, pop vertex, seed vertex) is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is shown. Each item
// gives one result: rsp_valid is high for exactly one cycle with the rsp_ fields; the
// receiver must take it then, it cannot hold the block off.
// From the accepting edge, pop, seed and the unused code pass through the destination read
// and S_RESP; a relax reads the source first, and an improving relax waits in S_DIV for
// the divider before S_RESP. A new item can be taken in the result cycle, but not before.
// The sequence is set by the vertex memory, which reads one entry at a time (source read,
// then destination read) and writes back in S_RESP, and by the bit-serial divider that
// forms distance / delta (31 steps, then a done strobe).
// csr_wr_en writes delta (bucket_width) at any time the block is idle; 0 acts as 1.
// After reset the block sweeps the vertex memory back to infinity / no parent / empty,
// one entry per cycle: busy stays high until every entry is written and no item is taken
// meanwhile, configuration writes are taken as usual. The pending count clears at once.
module delta_stepping_relax_engine_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dsre_pkg::OP_W-1:0]        req_operation,
   input  logic [dsre_pkg::VTX_W-1:0]       req_src_vertex,
   input  logic [dsre_pkg::VTX_W-1:0]       req_dst_vertex,
   input  logic [dsre_pkg::WGT_W-1:0]       req_weight,
   input  logic [dsre_pkg::BKT_W-1:0]       req_current_bucket,
   input  logic                             csr_wr_en,
   input  logic [dsre_pkg::DELTA_W-1:0]     csr_wr_data,
   output logic                             rsp_valid,
   output logic                             rsp_accepted,
   output logic [dsre_pkg::DIST_W-1:0]      rsp_distance,
   output logic [dsre_pkg::PAR_W-1:0]       rsp_parent,
   output logic [dsre_pkg::BKT_W-1:0]       rsp_bucket,
   output logic                             rsp_current_hit,
   output logic [dsre_pkg::PEND_W-1:0]      rsp_pending_total
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SRC   = 6'b000100,
      S_DST   = 6'b001000,
      S_DIV   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type                          state_ff, state_in;
   logic [dsre_pkg::VTX_W-1:0]         clr_ff, clr_in;
   logic [dsre_pkg::DELTA_W-1:0]       delta_ff;
   logic [dsre_pkg::PEND_W-1:0]        pend_ff, pend_in;

   logic [dsre_pkg::OP_W-1:0]          op_ff;
   logic [dsre_pkg::VTX_W-1:0]         src_ff, dst_ff;
   logic [dsre_pkg::WGT_W-1:0]         wgt_ff;
   logic [dsre_pkg::BKT_W-1:0]         cur_ff;
   logic [dsre_pkg::DIST_W-1:0]        sum_ff, sum_in;
   logic                               improve_ff;
   dsre_pkg::entry_type                rec_ff;

   dsre_pkg::entry_type                store_mem [dsre_pkg::VERTICES];
   dsre_pkg::entry_type                mem_q_ff;
   logic [dsre_pkg::VTX_W-1:0]         rd_addr;
   logic                               wr_en;
   logic [dsre_pkg::VTX_W-1:0]         wr_addr;
   dsre_pkg::entry_type                wr_data;

   logic                               accept;
   logic [dsre_pkg::DIST_W:0]          sum_wide;
   logic [dsre_pkg::DELTA_W-1:0]       delta_eff;
   logic                               div_start, div_done;
   logic [dsre_pkg::BKT_W-1:0]         div_quo;

   dsre_pkg::entry_type                new_rec;
   logic                               upd_wr, upd_acc, upd_hit, pend_up, pend_down;

   logic                               rsp_valid_ff;
   logic                               rsp_acc_ff, rsp_hit_ff;
   dsre_pkg::entry_type                rsp_rec_ff;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // saturating path length through the edge
   assign sum_wide = {1'b0, mem_q_ff.path_len} + (dsre_pkg::DIST_W + 1)'(wgt_ff);
   assign sum_in   = (sum_wide > {1'b0, dsre_pkg::INF_DIST}) ? dsre_pkg::INF_DIST
                                                             : sum_wide[dsre_pkg::DIST_W-1:0];

   assign delta_eff = (delta_ff == '0) ? dsre_pkg::DELTA_W'(1) : delta_ff;
   assign div_start = (state_ff == S_DST) && (op_ff == dsre_pkg::OP_RELAX)
                      && (mem_q_ff.path_len > sum_ff);

   dsre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (delta_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + dsre_pkg::VTX_W'(1);
            if (clr_ff == dsre_pkg::VTX_W'(dsre_pkg::VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (req_operation == dsre_pkg::OP_RELAX) ? S_SRC : S_DST;
            end
         end
         S_SRC: begin
            state_in = S_DST;
         end
         S_DST: begin
            state_in = div_start ? S_DIV : S_RESP;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory read address: source first for a relax, then destination
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_addr = (req_operation == dsre_pkg::OP_RELAX) ? req_src_vertex : req_dst_vertex;
      end else begin
         rd_addr = dst_ff;
      end
   end

   // update rule on the destination entry
   always_comb begin
      new_rec   = rec_ff;
      upd_wr    = 1'b0;
      upd_acc   = 1'b0;
      upd_hit   = 1'b0;
      pend_up   = 1'b0;
      pend_down = 1'b0;
      case (op_ff)
         dsre_pkg::OP_RELAX: begin
            if (improve_ff) begin
               new_rec.path_len = sum_ff;
               new_rec.parent   = dsre_pkg::PAR_W'(src_ff);
               new_rec.bucket   = div_quo;
               upd_wr  = 1'b1;
               upd_acc = 1'b1;
               upd_hit = (div_quo == cur_ff);
               pend_up = (rec_ff.bucket == dsre_pkg::EMPTY_BKT);
            end
         end
         dsre_pkg::OP_POP: begin
            if ((rec_ff.bucket != dsre_pkg::EMPTY_BKT) && (rec_ff.bucket == cur_ff)) begin
               new_rec.bucket = dsre_pkg::EMPTY_BKT;
               upd_wr    = 1'b1;
               upd_acc   = 1'b1;
               pend_down = 1'b1;
            end
         end
         dsre_pkg::OP_SEED: begin
            new_rec.path_len = '0;
            new_rec.parent   = dsre_pkg::PAR_W'(dst_ff);
            new_rec.bucket   = '0;
            upd_wr  = 1'b1;
            upd_acc = 1'b1;
            pend_up = (rec_ff.bucket == dsre_pkg::EMPTY_BKT);
         end
         default: begin
            upd_wr = 1'b0;
         end
      endcase
   end

   // saturating pending count
   always_comb begin
      pend_in = pend_ff;
      if (state_ff == S_RESP) begin
         if (pend_up && (pend_ff != dsre_pkg::PEND_MAX)) begin
            pend_in = pend_ff + dsre_pkg::PEND_W'(1);
         end else if (pend_down && (pend_ff != '0)) begin
            pend_in = pend_ff - dsre_pkg::PEND_W'(1);
         end
      end
   end

   // memory write port: clearing sweep or write-back
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = dsre_pkg::ENTRY_RESET;
      end else begin
         wr_en   = (state_ff == S_RESP) && upd_wr;
         wr_addr = dst_ff;
         wr_data = new_rec;
      end
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= store_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         delta_ff     <= dsre_pkg::DELTA_W'(1);
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= (state_ff == S_RESP);
         if (csr_wr_en) begin
            delta_ff <= csr_wr_data;
         end
      end
   end

   // item and entry registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         src_ff <= req_src_vertex;
         dst_ff <= req_dst_vertex;
         wgt_ff <= req_weight;
         cur_ff <= req_current_bucket;
      end
      if (state_ff == S_SRC) begin
         sum_ff <= sum_in;
      end
      if (state_ff == S_DST) begin
         rec_ff     <= mem_q_ff;
         improve_ff <= div_start;
      end
      if (state_ff == S_RESP) begin
         rsp_rec_ff <= new_rec;
         rsp_acc_ff <= upd_acc;
         rsp_hit_ff <= upd_hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_distance      = rsp_rec_ff.path_len;
   assign rsp_parent        = rsp_rec_ff.parent;
   assign rsp_bucket        = rsp_rec_ff.bucket;
   assign rsp_current_hit   = rsp_hit_ff;
   assign rsp_pending_total = pend_ff;

endmodule

// ===== hw/rtl/dsre_checker.sv =====
// port-level checks of the relax engine, bound to the top level
`include "delta_stepping_relax_engine_core_assert.svh"

module dsre_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             rsp_valid,
   input  logic                             rsp_accepted,
   input  logic [dsre_pkg::DIST_W-1:0]      rsp_distance,
   input  logic [dsre_pkg::BKT_W-1:0]       rsp_bucket,
   input  logic                             rsp_current_hit
);

   // a taken item keeps the block busy in the next cycle
   `DSRE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // a result strobe lasts one cycle only
   `DSRE_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid)

   // a hit on the current bucket comes only with an accepted, filed vertex
   `DSRE_ASSERT_NOW(a_hit_filed, rsp_valid && rsp_current_hit, rsp_accepted && (rsp_bucket != dsre_pkg::EMPTY_BKT))

   // an accepted item never leaves its vertex unreached
   `DSRE_ASSERT_NOW(a_acc_reached, rsp_valid && rsp_accepted, rsp_distance != dsre_pkg::INF_DIST)

endmodule

bind delta_stepping_relax_engine_core dsre_checker u_dsre_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench of the delta-stepping relax engine core
`timescale 1ns / 100ps

module tb;
   import dsre_pkg::*;

   // operation code with no function in the block
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 48;
   localparam int PHASE_ITEMS  = 250;

   typedef struct {
      logic              accepted;
      logic [DIST_W-1:0] distance;
      logic [PAR_W-1:0]  parent;
      logic [BKT_W-1:0]  bucket;
      logic              current_hit;
      logic [PEND_W-1:0] pending_total;
   } vertex_report_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_operation;
   logic [VTX_W-1:0]    req_src_vertex;
   logic [VTX_W-1:0]    req_dst_vertex;
   logic [WGT_W-1:0]    req_weight;
   logic [BKT_W-1:0]    req_current_bucket;
   logic                csr_wr_en;
   logic [DELTA_W-1:0]  csr_wr_data;
   logic                rsp_valid;
   logic                rsp_accepted;
   logic [DIST_W-1:0]   rsp_distance;
   logic [PAR_W-1:0]    rsp_parent;
   logic [BKT_W-1:0]    rsp_bucket;
   logic                rsp_current_hit;
   logic [PEND_W-1:0]   rsp_pending_total;

   // shadow copy of the vertex store, the pending count and the delta register
   logic [DIST_W-1:0]   path_dist [VERTICES];
   logic [PAR_W-1:0]    path_parent [VERTICES];
   logic [BKT_W-1:0]    path_bucket [VERTICES];
   logic [PEND_W-1:0]   queued_vertices;
   logic [DELTA_W-1:0]  bucket_span;

   vertex_report_type   pending_reports [$];
   vertex_report_type   seen_report;
   int                  fail_count;
   int                  sender_idle_pct;

   delta_stepping_relax_engine_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_src_vertex     (req_src_vertex),
      .req_dst_vertex     (req_dst_vertex),
      .req_weight         (req_weight),
      .req_current_bucket (req_current_bucket),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_distance       (rsp_distance),
      .rsp_parent         (rsp_parent),
      .rsp_bucket         (rsp_bucket),
      .rsp_current_hit    (rsp_current_hit),
      .rsp_pending_total  (rsp_pending_total)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // saturating path length through an edge
   function automatic logic [31:0] path_through(input logic [VTX_W-1:0] src,
                                                input logic [WGT_W-1:0] weight);
      logic [31:0] sum;
      sum = {1'b0, path_dist[src]} + {16'd0, weight};
      if (sum > {1'b0, INF_DIST})
         sum = {1'b0, INF_DIST};
      return sum;
   endfunction

   // bucket index for a distance under the current delta
   function automatic logic [31:0] bucket_of(input logic [31:0] path_len);
      logic [31:0] span;
      span = (bucket_span == '0) ? 32'd1 : {16'd0, bucket_span};
      return path_len / span;
   endfunction

   // apply one item to the shadow store and form the report it should give
   function automatic vertex_report_type update_shortest_paths(
      input logic [OP_W-1:0]  op,
      input logic [VTX_W-1:0] src,
      input logic [VTX_W-1:0] dst,
      input logic [WGT_W-1:0] weight,
      input logic [BKT_W-1:0] cur);
      vertex_report_type rep;
      logic [31:0]       sum;
      logic [31:0]       new_bkt;
      rep.accepted    = 1'b0;
      rep.current_hit = 1'b0;
      case (op)
         OP_RELAX: begin
            sum = path_through(src, weight);
            if ({1'b0, path_dist[dst]} > sum) begin
               new_bkt = bucket_of(sum);
               if (path_bucket[dst] == EMPTY_BKT && queued_vertices != PEND_MAX)
                  queued_vertices++;
               path_dist[dst]   = sum[DIST_W-1:0];
               path_parent[dst] = PAR_W'(src);
               path_bucket[dst] = new_bkt[BKT_W-1:0];
               rep.accepted     = 1'b1;
               rep.current_hit  = (new_bkt[BKT_W-1:0] == cur);
            end
         end
         OP_POP: begin
            if (path_bucket[dst] != EMPTY_BKT && path_bucket[dst] == cur) begin
               path_bucket[dst] = EMPTY_BKT;
               if (queued_vertices != '0)
                  queued_vertices--;
               rep.accepted = 1'b1;
            end
         end
         OP_SEED: begin
            if (path_bucket[dst] == EMPTY_BKT && queued_vertices != PEND_MAX)
               queued_vertices++;
            path_dist[dst]   = '0;
            path_parent[dst] = PAR_W'(dst);
            path_bucket[dst] = '0;
            rep.accepted     = 1'b1;
         end
         default: ;
      endcase
      rep.distance      = path_dist[dst];
      rep.parent        = path_parent[dst];
      rep.bucket        = path_bucket[dst];
      rep.pending_total = queued_vertices;
      return rep;
   endfunction

   // offer one item, hold it until taken, then record its expected report
   task automatic send_item(input logic [OP_W-1:0]  op,
                            input logic [VTX_W-1:0] src,
                            input logic [VTX_W-1:0] dst,
                            input logic [WGT_W-1:0] weight,
                            input logic [BKT_W-1:0] cur);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start              <= 1'b1;
      req_operation      <= op;
      req_src_vertex     <= src;
      req_dst_vertex     <= dst;
      req_weight         <= weight;
      req_current_bucket <= cur;
      do
         @(posedge clock);
      while (busy);
      pending_reports.push_back(update_shortest_paths(op, src, dst, weight, cur));
   endtask

   // stop offering items and let every report come back
   task automatic drain_reports();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write delta while the block is idle
   task automatic write_bucket_span(input logic [DELTA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      bucket_span = value;
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result checking against the oldest expected report
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            $error("result item with no expected report waiting");
            fail_count++;
         end else begin
            seen_report = pending_reports.pop_front();
            compare_field("accepted", 32'(seen_report.accepted), 32'(rsp_accepted));
            compare_field("distance", 32'(seen_report.distance), 32'(rsp_distance));
            compare_field("parent", 32'(seen_report.parent), 32'(rsp_parent));
            compare_field("bucket", 32'(seen_report.bucket), 32'(rsp_bucket));
            compare_field("current_hit", 32'(seen_report.current_hit),
                          32'(rsp_current_hit));
            compare_field("pending_total", 32'(seen_report.pending_total),
                          32'(rsp_pending_total));
         end
      end
   end

   // mostly a small hot set of vertices, sometimes anywhere
   function automatic logic [VTX_W-1:0] pick_vertex();
      if ($urandom_range(0, 99) < 70)
         return VTX_W'($urandom_range(0, 63));
      return VTX_W'($urandom_range(0, VERTICES - 1));
   endfunction

   // edge weights: small ones make improvements likely, plus extremes
   function automatic logic [WGT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return WGT_W'($urandom);
         default: return WGT_W'($urandom_range(0, 40));
      endcase
   endfunction

   task automatic test_reset_state();
      reset              <= 1'b1;
      start              <= 1'b0;
      req_operation      <= OP_RELAX;
      req_src_vertex     <= '0;
      req_dst_vertex     <= '0;
      req_weight         <= '0;
      req_current_bucket <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      for (int v = 0; v < VERTICES; v++) begin
         path_dist[v]   = INF_DIST;
         path_parent[v] = NO_PARENT;
         path_bucket[v] = EMPTY_BKT;
      end
      queued_vertices = '0;
      bucket_span     = 16'd1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // hand-picked items over the corners of each operation
   task automatic test_directed_corners();
      sender_idle_pct = 0;
      send_item(OP_SEED, '0, 10'd0, '0, '0);
      // unreached source saturates and changes nothing
      send_item(OP_RELAX, 10'd1023, 10'd5, 16'hFFFF, '0);
      send_item(OP_RELAX, 10'd0, 10'd1023, 16'hFFFF, 31'd65535);
      send_item(OP_RELAX, 10'd0, 10'd1, 16'd0, '0);
      // equal length is no improvement
      send_item(OP_RELAX, 10'd1, 10'd1023, 16'hFFFF, '0);
      send_item(OP_RELAX, 10'd0, 10'd1023, 16'd100, 31'd7);
      send_item(OP_POP, '0, 10'd1023, '0, 31'd99);
      send_item(OP_POP, '0, 10'd1023, '0, 31'd100);
      send_item(OP_POP, '0, 10'd1023, '0, 31'd100);
      // pop with the empty mark as current bucket
      send_item(OP_POP, '0, 10'd5, '0, EMPTY_BKT);
      send_item(OP_SEED, '0, 10'd1, '0, '0);
      send_item(OP_SEED, '0, 10'd1023, '0, '0);
      send_item(OP_UNUSED, 10'd1023, 10'd0, 16'hFFFF, EMPTY_BKT);
      send_item(OP_RELAX, 10'd0, 10'd0, 16'd0, '0);
      send_item(OP_POP, '0, 10'd0, '0, '0);
      send_item(OP_SEED, '0, 10'd682, '0, '0);
      send_item(OP_RELAX, 10'd682, 10'd341, 16'hAAAA, 31'h2AAAAAAA);
      send_item(OP_RELAX, 10'd341, 10'd682, 16'h5555, 31'h55555555);
      send_item(OP_POP, '0, 10'd341, '0, 31'h0000AAAA);
      drain_reports();
      // zero delta acts as one
      write_bucket_span(16'd0);
      send_item(OP_RELAX, 10'd0, 10'd2, 16'd50000, 31'd50000);
      send_item(OP_RELAX, 10'd2, 10'd3, 16'd17, 31'd50017);
      drain_reports();
      write_bucket_span(16'hFFFF);
      send_item(OP_RELAX, 10'd0, 10'd4, 16'hFFFF, 31'd1);
      send_item(OP_POP, '0, 10'd4, '0, 31'd1);
      drain_reports();
   endtask

   // random traffic, mostly well-formed relax from reached vertices and pop
   task automatic test_random_traffic(input logic [DELTA_W-1:0] span, input int idle_pct,
                                      input int item_count);
      logic [OP_W-1:0]  op;
      logic [VTX_W-1:0] src;
      logic [VTX_W-1:0] dst;
      logic [WGT_W-1:0] weight;
      logic [BKT_W-1:0] cur;
      logic [31:0]      sum;
      int               done;
      int               pick;
      write_bucket_span(span);
      sender_idle_pct = idle_pct;
      done = 0;
      while (done < item_count) begin
         pick   = $urandom_range(0, 99);
         src    = VTX_W'($urandom);
         dst    = pick_vertex();
         weight = WGT_W'($urandom);
         cur    = BKT_W'($urandom);
         if (pick < 55) begin
            op = OP_RELAX;
            src = pick_vertex();
            for (int t = 0; t < 8 && path_dist[src] == INF_DIST; t++)
               src = pick_vertex();
            weight = pick_weight();
            sum = path_through(src, weight);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: cur = BKT_W'(bucket_of(sum));
               4, 5:       cur = path_bucket[src];
               6:          cur = EMPTY_BKT;
               default:    cur = BKT_W'($urandom_range(0, 3));
            endcase
         end else if (pick < 82) begin
            op = OP_POP;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: cur = path_bucket[dst];
               7:                   cur = path_bucket[dst] + 1'b1;
               default:             ;
            endcase
         end else if (pick < 92) begin
            op = OP_SEED;
         end else if (pick < 95) begin
            op = OP_UNUSED;
         end else begin
            // noise: anything at all in every field
            op  = OP_W'($urandom);
            dst = VTX_W'($urandom);
         end
         send_item(op, src, dst, weight, cur);
         if (op != OP_UNUSED)
            done++;
      end
      drain_reports();
   endtask

   initial begin
      fail_count      = 0;
      sender_idle_pct = 0;
      test_reset_state();
      test_directed_corners();
      test_random_traffic(16'hFFFF, 0, PHASE_ITEMS);
      test_random_traffic(16'd1, 82, PHASE_ITEMS);
      test_random_traffic(DELTA_W'($urandom_range(2, 300)), 30, PHASE_ITEMS);
      test_random_traffic(16'd7, 0, PHASE_ITEMS);
      test_random_traffic(DELTA_W'($urandom), 82, PHASE_ITEMS);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dsre_pkg.sv
hw/rtl/dsre_div.sv
hw/rtl/delta_stepping_relax_engine_core.sv
hw/rtl/dsre_checker.sv
tb/tb.sv
